[sv/lsb_audio_stego_codec_defines.svh]
// Assertion macros shared by the LSB audio steganography codec RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef LSB_AUDIO_STEGO_CODEC_DEFINES_SVH
`define LSB_AUDIO_STEGO_CODEC_DEFINES_SVH

// Plain property, checked at every rising clock edge outside reset.
`define LSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define LSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lsc_pkg.sv]
// Package for the LSB audio steganography codec: payload structs, codes and constants.
// No dependencies; imported by lsb_audio_stego_codec.
package lsc_pkg;

    localparam int unsigned HDR_BITS   = 32;
    localparam int unsigned GROUP_BITS = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE           = 2'd0;
    localparam logic [1:0] REG_SKIP_BYTES     = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd2;
    localparam logic [1:0] REG_COVER_LENGTH   = 2'd3;

    // Operating modes.
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_COVER   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_LENGTH  = 2'd2;

    localparam logic [15:0] SKIP_BYTES_RESET = 16'd44;

    typedef struct packed {
        logic [7:0] cover_byte;
        logic [7:0] payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  out_kind;
        logic [31:0] recovered_length;
        logic        last;
        logic        no_room;
    } out_item_t;

endpackage

[sv/lsb_audio_stego_codec.sv]
// LSB audio steganography codec, top level; depends on lsc_pkg and on the assertion macros in
// lsb_audio_stego_codec_defines.svh. The block takes one cover-audio byte per transfer and hides
// (mode 0) or recovers (mode 1) one data bit in its least significant bit. When embedding, the
// first skip_bytes bytes pass untouched, the next 32 carry payload_length LSB first, each payload
// byte is then spread over 8 bytes bit 0 first (payload_byte is sampled at the start of each
// group), and the rest passes untouched; if the payload does not fit the cover, only the skip
// bytes come out, flagged no_room, and later transfers give no result. When extracting, the skip
// bytes are dropped, the recovered length is reported once and each rebuilt byte follows, the
// final one marked last. The step logic sits between the input handshake and a single result
// register, so a new transfer is taken in every cycle as long as the result register is empty
// or being drained in that cycle. Results are registered and appear in the cycle after the
// transfer that causes them. Configuration registers are written through cfg_we, cfg_index
// and cfg_wdata and should only change while the stream is idle.

`include "lsb_audio_stego_codec_defines.svh"

module lsb_audio_stego_codec import lsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    // The stream walks through the skip region, the 32-bit length header, the payload groups
    // and finally a tail in which the cover passes through (embed) or is ignored (extract).
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_HDR,
        PH_PAY,
        PH_TAIL
    } phase_t;

    localparam logic [2:0] GROUP_LAST = 3'(GROUP_BITS - 1);

    // Configuration registers.
    logic        mode_reg;
    logic [15:0] skip_bytes_reg;
    logic [31:0] payload_length_reg;
    logic [31:0] cover_length_reg;

    // Stream state.
    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [31:0] length_word_reg, length_word_next;

    // Result register.
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    // Step logic.
    logic        s_fire;
    logic        room;
    logic [35:0] need;
    logic        in_skip;
    phase_t      phase_eff;
    logic [31:0] pos_eff;
    logic [31:0] pos_inc;
    logic        hdr_done;
    logic [7:0]  sb_embed;
    logic [7:0]  sb_extract;
    logic [31:0] lw_extract;
    logic        step_emit;
    out_item_t   step_res;

    assign s_fire  = s_valid && s_ready;
    // The result register can take a new result when it is empty or drains in this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Room check, carried out at full width so that a large length cannot wrap:
    // (4 + length) * 8 + skip must stay below the cover length.
    assign need = {1'b0, payload_length_reg, 3'b000} + 36'(4 * GROUP_BITS)
                + {20'd0, skip_bytes_reg};
    assign room = need < {4'd0, cover_length_reg};

    // Leaving the skip region falls straight through into the first header byte.
    assign in_skip   = (phase_reg == PH_SKIP) && (pos_reg < {16'd0, skip_bytes_reg});
    assign phase_eff = (phase_reg == PH_SKIP) ? PH_HDR : phase_reg;
    assign pos_eff   = (phase_reg == PH_SKIP) ? 32'd0 : pos_reg;
    assign pos_inc   = pos_eff + 32'd1;
    assign hdr_done  = pos_inc >= 32'(HDR_BITS);

    // The payload byte is latched at the start of each group when embedding; when extracting,
    // the shift byte and the length word are cleared at the start of their fields.
    assign sb_embed   = (bit_index_reg == 3'd0) ? s_data.payload_byte : shift_byte_reg;
    assign sb_extract = ((bit_index_reg == 3'd0) ? 8'd0 : shift_byte_reg)
                      | (8'(s_data.cover_byte[0]) << bit_index_reg);
    assign lw_extract = ((pos_eff == 32'd0) ? 32'd0 : length_word_reg)
                      | (32'(s_data.cover_byte[0]) << pos_eff[4:0]);

    always_comb begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        length_word_next = length_word_reg;
        step_emit        = 1'b0;
        step_res         = '0;
        step_res.out_kind = KIND_COVER;

        if (in_skip) begin
            pos_next = pos_reg + 32'd1;
            if (mode_reg == MODE_EMBED) begin
                step_emit        = 1'b1;
                step_res.out_byte = s_data.cover_byte;
                step_res.no_room  = !room;
            end
        end else begin
            phase_next = phase_eff;
            pos_next   = pos_eff;
            if (mode_reg == MODE_EMBED) begin
                // Without room nothing follows the skip bytes.
                if (room) begin
                    case (phase_eff)
                        PH_HDR: begin
                            step_emit         = 1'b1;
                            step_res.out_byte = {s_data.cover_byte[7:1],
                                                 payload_length_reg[pos_eff[4:0]]};
                            pos_next          = pos_inc;
                            if (hdr_done) begin
                                phase_next     = (payload_length_reg == 32'd0) ? PH_TAIL
                                                                               : PH_PAY;
                                pos_next       = 32'd0;
                                bit_index_next = 3'd0;
                                step_res.last  = (payload_length_reg == 32'd0);
                            end
                        end
                        PH_PAY: begin
                            step_emit = 1'b1;
                            if (pos_eff >= payload_length_reg) begin
                                phase_next        = PH_TAIL;
                                step_res.out_byte = s_data.cover_byte;
                            end else begin
                                shift_byte_next   = sb_embed;
                                step_res.out_byte = {s_data.cover_byte[7:1],
                                                     sb_embed[bit_index_reg]};
                                if (bit_index_reg == GROUP_LAST) begin
                                    bit_index_next = 3'd0;
                                    pos_next       = pos_inc;
                                    if (pos_inc >= payload_length_reg) begin
                                        step_res.last = 1'b1;
                                        phase_next    = PH_TAIL;
                                    end
                                end else begin
                                    bit_index_next = bit_index_reg + 3'd1;
                                end
                            end
                        end
                        default: begin
                            step_emit         = 1'b1;
                            step_res.out_byte = s_data.cover_byte;
                        end
                    endcase
                end
            end else begin
                case (phase_eff)
                    PH_HDR: begin
                        length_word_next = lw_extract;
                        pos_next         = pos_inc;
                        if (hdr_done) begin
                            phase_next                = (lw_extract == 32'd0) ? PH_TAIL : PH_PAY;
                            pos_next                  = 32'd0;
                            bit_index_next            = 3'd0;
                            step_emit                 = 1'b1;
                            step_res.out_kind         = KIND_LENGTH;
                            step_res.recovered_length = lw_extract;
                        end
                    end
                    PH_PAY: begin
                        if (pos_eff >= length_word_reg) begin
                            phase_next = PH_TAIL;
                        end else begin
                            shift_byte_next = sb_extract;
                            if (bit_index_reg != GROUP_LAST) begin
                                bit_index_next = bit_index_reg + 3'd1;
                            end else begin
                                bit_index_next    = 3'd0;
                                pos_next          = pos_inc;
                                step_emit         = 1'b1;
                                step_res.out_kind = KIND_PAYLOAD;
                                step_res.out_byte = sb_extract;
                                if (pos_inc >= length_word_reg) begin
                                    step_res.last = 1'b1;
                                    phase_next    = PH_TAIL;
                                end
                            end
                        end
                    end
                    default: begin
                        // After extraction every further cover byte is dropped.
                    end
                endcase
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_EMBED;
            skip_bytes_reg     <= SKIP_BYTES_RESET;
            payload_length_reg <= 32'd0;
            cover_length_reg   <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:           mode_reg           <= cfg_wdata[0];
                REG_SKIP_BYTES:     skip_bytes_reg     <= cfg_wdata[15:0];
                REG_PAYLOAD_LENGTH: payload_length_reg <= cfg_wdata;
                REG_COVER_LENGTH:   cover_length_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Stream state moves on once per input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SKIP;
            pos_reg         <= 32'd0;
            bit_index_reg   <= 3'd0;
            shift_byte_reg  <= 8'd0;
            length_word_reg <= 32'd0;
        end else if (s_fire) begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            bit_index_reg   <= bit_index_next;
            shift_byte_reg  <= shift_byte_next;
            length_word_reg <= length_word_next;
        end
    end

    // Result register: loaded on a transfer that yields a result, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= step_emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && step_emit) begin
            m_data_reg <= step_res;
        end
    end

    `LSC_ASSERT_IMPL(a_hdr_pos_bound, phase_reg == PH_HDR, pos_reg < 32'(HDR_BITS),
        "header position ran past the length field")
    `LSC_ASSERT_NEXT(a_extract_tail_silent,
        s_fire && (mode_reg == MODE_EXTRACT) && (phase_reg == PH_TAIL), !m_valid_reg,
        "result produced after extraction finished")
    `LSC_ASSERT_NEXT(a_embed_keeps_msbs, s_fire && (mode_reg == MODE_EMBED) && step_emit,
        m_data_reg.out_byte[7:1] == $past(s_data.cover_byte[7:1]),
        "embedding altered bits above the LSB")
    `LSC_ASSERT_IMPL(a_length_report_clean,
        m_valid_reg && (m_data_reg.out_kind == KIND_LENGTH),
        !m_data_reg.last && (m_data_reg.out_byte == 8'd0) && !m_data_reg.no_room,
        "length report carries stray fields")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the LSB audio steganography codec (lsb_audio_stego_codec).
// It depends on lsc_pkg for the payload structs, register indexes, modes and result kinds.
// A transfer-level predictor of the codec runs alongside the RTL, and a scoreboard checks its results.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    // The run is bounded by a cycle counter, set well above what about 1600 transfers need
    // even with a random source gap and sink stall around each of them.
    localparam int unsigned CYCLE_LIMIT  = 250000;
    // Random transfers to run, not counting tail extraction batches, which the block ignores.
    localparam int unsigned RANDOM_ITEMS = 1450;
    // Results are registered, so a margin after each batch lets the last one settle.
    localparam int unsigned SETTLE_CYCLES = 4;

    // The predictor tracks the codec's position in the stream with the same four phases.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TAIL
    } stream_phase_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;

    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;

    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;

    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_MODE;
    logic [31:0] cfg_wdata = '0;

    // The predictor's copy of the configuration registers, starting at their reset values.
    logic          cfg_mode = MODE_EMBED;
    logic [15:0]   cfg_skip = SKIP_BYTES_RESET;
    logic [31:0]   cfg_plen = '0;
    logic [31:0]   cfg_clen = '0;

    // The predictor's copy of the codec's stream state.
    stream_phase_t st_phase  = PH_SKIP;
    logic [31:0]   pos_cnt   = '0;
    logic [2:0]    bit_idx   = '0;
    logic [7:0]    shift_reg = '0;
    logic [31:0]   len_word  = '0;

    // Cover bytes waiting to be sent, and the results the predictor says must come back.
    in_item_t      cover_stream[$];
    out_item_t     stego_results[$];

    int unsigned   items_queued   = 0;
    int unsigned   items_accepted = 0;
    int unsigned   results_seen   = 0;
    int unsigned   reg_writes     = 0;
    int unsigned   random_items   = 0;
    int unsigned   errors         = 0;
    int unsigned   cycle_count    = 0;

    // Set at the rising edge that completes an input transfer and consumed by the driver.
    bit            in_taken  = 1'b0;
    // Random idling on both sides; switched off for the last part of the run.
    bit            idle_en   = 1'b1;
    int unsigned   src_gap   = 0;
    int unsigned   snk_stall = 0;

    lsb_audio_stego_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Works out what one accepted cover byte does to the codec and whether it yields a result.
    // Embedding and extraction share the phase machine, so a change of mode carries on from
    // wherever the stream happens to be.
    function automatic bit stego_step(input in_item_t item, output out_item_t res);
        logic [36:0] need;
        logic        room;
        logic        lsb;
        res = '0;
        if (cfg_mode == MODE_EMBED) begin
            // The room check is done at full width so that a huge length cannot wrap round.
            need = {5'd0, cfg_plen} + 37'd4;
            need = need * 37'd8 + {21'd0, cfg_skip};
            room = need < {5'd0, cfg_clen};
            res.out_byte = item.cover_byte;
            res.out_kind = KIND_COVER;
            if (st_phase == PH_SKIP) begin
                if (pos_cnt < {16'd0, cfg_skip}) begin
                    pos_cnt++;
                    res.no_room = !room;
                    return 1'b1;
                end
                st_phase = PH_HEADER;
                pos_cnt  = '0;
            end
            // Without room nothing comes out and the state stands still.
            if (!room) return 1'b0;
            case (st_phase)
                PH_HEADER: begin
                    res.out_byte[0] = cfg_plen[pos_cnt[4:0]];
                    pos_cnt++;
                    if (pos_cnt >= HDR_BITS) begin
                        st_phase = (cfg_plen == 0) ? PH_TAIL : PH_PAYLOAD;
                        pos_cnt  = '0;
                        bit_idx  = '0;
                        // A zero length marks the final header sample as the last hidden bit.
                        res.last = (cfg_plen == 0);
                    end
                end
                PH_PAYLOAD: begin
                    if (pos_cnt >= cfg_plen) begin
                        st_phase = PH_TAIL;
                    end else begin
                        if (bit_idx == 0) shift_reg = item.payload_byte;
                        res.out_byte[0] = shift_reg[bit_idx];
                        if (bit_idx == GROUP_BITS - 1) begin
                            bit_idx = '0;
                            pos_cnt++;
                            if (pos_cnt >= cfg_plen) begin
                                res.last = 1'b1;
                                st_phase = PH_TAIL;
                            end
                        end else begin
                            bit_idx++;
                        end
                    end
                end
                default: ;
            endcase
            return 1'b1;
        end

        lsb = item.cover_byte[0];
        if (st_phase == PH_SKIP) begin
            if (pos_cnt < {16'd0, cfg_skip}) begin
                pos_cnt++;
                return 1'b0;
            end
            st_phase = PH_HEADER;
            pos_cnt  = '0;
        end
        case (st_phase)
            PH_HEADER: begin
                if (pos_cnt == 0) len_word = '0;
                len_word[pos_cnt[4:0]] = len_word[pos_cnt[4:0]] | lsb;
                pos_cnt++;
                if (pos_cnt < HDR_BITS) return 1'b0;
                st_phase = (len_word == 0) ? PH_TAIL : PH_PAYLOAD;
                pos_cnt  = '0;
                bit_idx  = '0;
                res.out_kind         = KIND_LENGTH;
                res.recovered_length = len_word;
                return 1'b1;
            end
            PH_PAYLOAD: begin
                if (pos_cnt >= len_word) begin
                    st_phase = PH_TAIL;
                    return 1'b0;
                end
                if (bit_idx == 0) shift_reg = '0;
                shift_reg[bit_idx] = shift_reg[bit_idx] | lsb;
                if (bit_idx < GROUP_BITS - 1) begin
                    bit_idx++;
                    return 1'b0;
                end
                bit_idx = '0;
                pos_cnt++;
                res.out_byte = shift_reg;
                res.out_kind = KIND_PAYLOAD;
                if (pos_cnt >= len_word) begin
                    res.last = 1'b1;
                    st_phase = PH_TAIL;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Writes one register at a falling edge so that it is taken at the next rising edge.
    // The predictor's copy is updated at once, which is safe because the stream is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MODE:           cfg_mode = val[0];
            REG_SKIP_BYTES:     cfg_skip = val[15:0];
            REG_PAYLOAD_LENGTH: cfg_plen = val;
            REG_COVER_LENGTH:   cfg_clen = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    task automatic queue_cover(input logic [7:0] cb, input logic [7:0] pb);
        in_item_t item;
        item.cover_byte   = cb;
        item.payload_byte = pb;
        cover_stream.push_back(item);
        items_queued++;
    endtask

    // Waits until every queued transfer has been taken and every predicted result has been
    // seen, then lets the settle margin pass in case an ignored byte is still in flight.
    task automatic wait_drained();
        while (items_accepted != items_queued || stego_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Source driver. A new cover byte is presented at a falling edge only once the previous
    // one has gone over in a transfer; until then valid and the payload are held as they are.
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            in_taken = 1'b0;
            if (src_gap != 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (cover_stream.size() != 0) begin
                s_data  <= cover_stream.pop_front();
                s_valid <= 1'b1;
                // Now and then a gap is opened before the next byte.
                if (idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 14);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Sink driver. Ready drops in random bursts while idling is allowed.
    always @(negedge aclk) begin
        if (snk_stall != 0) begin
            snk_stall--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            snk_stall = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor. Both channels are sampled at the rising edge. A result transfer is checked
    // against the oldest prediction; an input transfer is run through the predictor. No
    // result can leave in the same cycle as the input that causes it, so the order of the
    // two halves does not matter.
    always @(posedge aclk) begin : monitor
        out_item_t want;
        out_item_t next_res;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (stego_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    errors++;
                end else begin
                    want = stego_results.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(m_data.out_byte));
                    check_field("out_kind", 32'(want.out_kind), 32'(m_data.out_kind));
                    check_field("recovered_length", want.recovered_length,
                                m_data.recovered_length);
                    check_field("last", 32'(want.last), 32'(m_data.last));
                    check_field("no_room", 32'(want.no_room), 32'(m_data.no_room));
                end
            end
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                items_accepted++;
                if (stego_step(s_data, next_res)) stego_results.push_back(next_res);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, stego_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus. The codec's stream state is cleared only by reset, and reset is applied once,
    // so the run is one pass through skip region, header, payload and tail. Mode and register
    // changes between batches steer that pass through both the embedding and the extraction
    // paths. Every batch is followed by a pause until all its results have arrived.
    initial begin : stimulus
        logic [7:0]  hdr_len;
        logic [31:0] pick;
        int unsigned n;
        bit          to_extract;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: embedding, 44 skip bytes and a cover length of zero, so there is
        // no room and the skip bytes come out flagged. The extremes of both fields go first.
        queue_cover(8'h00, 8'hFF);
        queue_cover(8'hFF, 8'h00);
        queue_cover(8'h55, 8'hAA);
        queue_cover(8'hAA, 8'h55);
        wait_drained();

        // Skip bytes are dropped silently when extracting.
        write_reg(REG_MODE, {31'd0, MODE_EXTRACT});
        repeat (3) queue_cover(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        wait_drained();

        // Back to embedding with the largest cover length: skip bytes now pass without the flag.
        write_reg(REG_MODE, {31'd0, MODE_EMBED});
        write_reg(REG_COVER_LENGTH, 32'hFFFF_FFFF);
        repeat (3) queue_cover(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        wait_drained();

        // No skip region and no cover: the stream enters the header but nothing comes out.
        write_reg(REG_COVER_LENGTH, 32'd0);
        write_reg(REG_SKIP_BYTES, 32'd0);
        queue_cover(8'hFF, 8'hFF);
        queue_cover(8'h00, 8'h00);
        wait_drained();

        // Skip, payload length and cover length at their top values. The room sum only fits
        // if it wraps at 32 bits, so the codec must still stay silent here.
        write_reg(REG_SKIP_BYTES, 32'h0000_FFFF);
        write_reg(REG_PAYLOAD_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_COVER_LENGTH, 32'hFFFF_FFFF);
        queue_cover(8'h01, 8'hFF);
        queue_cover(8'hFE, 8'h00);
        wait_drained();

        // The header is shared out between the modes. The first eleven length bits are read
        // back in extraction, the next twenty are written from payload_length in embedding,
        // and the final one is read again so that the recovered length is reported.
        hdr_len = 8'($urandom_range(120, 160));
        write_reg(REG_MODE, {31'd0, MODE_EXTRACT});
        for (int i = 0; i < 11; i++)
            queue_cover({7'($urandom_range(0, 127)), (i < 8) ? hdr_len[i] : 1'b0},
                        8'($urandom_range(0, 255)));
        wait_drained();

        write_reg(REG_PAYLOAD_LENGTH, ($urandom & 32'h0FFF_F800) | 32'h0000_0800);
        write_reg(REG_SKIP_BYTES, $urandom_range(0, 65535));
        write_reg(REG_MODE, {31'd0, MODE_EMBED});
        repeat (20) queue_cover(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        wait_drained();

        write_reg(REG_MODE, {31'd0, MODE_EXTRACT});
        queue_cover({7'($urandom_range(0, 127)), 1'b0}, 8'($urandom_range(0, 255)));
        wait_drained();

        // Payload region. Batches alternate between the modes at random, so groups of eight
        // are often begun in one mode and finished in the other. The embedding length is kept
        // far above the byte count, so only extraction can end the region, with its last byte.
        while (st_phase != PH_TAIL) begin
            to_extract = ($urandom_range(0, 7) < 5);
            write_reg(REG_MODE, {31'd0, to_extract ? MODE_EXTRACT : MODE_EMBED});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_PAYLOAD_LENGTH, ($urandom & 32'h0FFF_FFFF) | 32'h0000_0800);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SKIP_BYTES, $urandom_range(0, 65535));
            // An occasional short cover can make embedding go quiet for a while.
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_COVER_LENGTH, $urandom_range(0, 65535));
            else if (cfg_clen != 32'hFFFF_FFFF)
                write_reg(REG_COVER_LENGTH, 32'hFFFF_FFFF);
            n = $urandom_range(1, 40);
            repeat (n) queue_cover(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            random_items += n;
            wait_drained();
        end

        // Tail region. Embedding passes the cover through whenever the settings leave room;
        // extraction batches are ignored and are not counted.
        while (random_items < RANDOM_ITEMS) begin
            to_extract = ($urandom_range(0, 7) == 0);
            write_reg(REG_MODE, {31'd0, to_extract ? MODE_EXTRACT : MODE_EMBED});
            if ($urandom_range(0, 1) == 0) begin
                pick = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 4096);
                write_reg(REG_PAYLOAD_LENGTH, pick);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SKIP_BYTES, $urandom_range(0, 65535));
            if ($urandom_range(0, 2) == 0) begin
                pick = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF;
                write_reg(REG_COVER_LENGTH, pick);
            end
            n = $urandom_range(1, 40);
            repeat (n) queue_cover(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (!to_extract) random_items += n;
            wait_drained();
        end

        // The last stretch runs with both sides always ready and plenty of room. Any gap or
        // stall still pending from the random part is dropped here.
        idle_en   = 1'b0;
        src_gap   = 0;
        snk_stall = 0;
        write_reg(REG_MODE, {31'd0, MODE_EMBED});
        write_reg(REG_PAYLOAD_LENGTH, 32'd1);
        write_reg(REG_COVER_LENGTH, 32'hFFFF_FFFF);
        repeat (60) queue_cover(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        wait_drained();

        $display("Covered %0d input transfers and %0d result transfers across %0d register writes,",
                 items_accepted, results_seen, reg_writes);
        $display("passing through skip, header, payload and tail with a recovered length of %0d.",
                 hdr_len);
        if (errors == 0 && stego_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/lsc_pkg.sv
sv/lsb_audio_stego_codec.sv
sim/tb_top.sv
